/* hw/rtl/crs_pkg.sv */
// Shared types, constants and table builder for the cipher rotor stage.
`timescale 1ns / 1ps

package crs_pkg;

    // Letter field width, fixed by the item format
    localparam int LETTER_W = 5;
    // Number of distinct letter field codes
    localparam int LETTER_CODES = 32;
    // Configuration register index width
    localparam int CFG_IDX_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTCH_LETTER = 4'd1;

    // Item operations
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_FORWARD = 2'd2,
        CMD_REVERSE = 2'd3
    } cmd_t;

    // Reduction table: every letter field code to its residue mod the alphabet size
    typedef logic [LETTER_CODES-1:0][LETTER_W-1:0] letter_lut_t;

    // Per-item context carried from the issue stage to the result stage
    typedef struct packed {
        cmd_t                cmd;
        logic [LETTER_W-1:0] pos_cur;
        logic [LETTER_W-1:0] pos_after;
        logic                past_notch;
    } issue_t;

    // Build the reduction table by counting up and wrapping at n
    function automatic letter_lut_t mod_lut(input int n);
        letter_lut_t lut;
        int          r;
        r = 0;
        for (int i = 0; i < LETTER_CODES; i++) begin
            lut[i] = LETTER_W'(r);
            r      = (r + 1 == n) ? 0 : r + 1;
        end
        return lut;
    endfunction

endpackage

/* hw/rtl/cipher_rotor_stage_unit.sv */
// Top level of the cipher rotor stage: ports, configuration registers, wiring tables.
`timescale 1ns / 1ps

// One rotor of a rotor cipher over an alphabet of ALPHABET_SIZE letters (A=0).
// Each input item loads a wiring entry, advances the rotor, or maps a letter
// forward or in reverse; each gives exactly one result item carrying the mapped
// letter (zero for load and advance), the rotor position after the item and the
// turnover flag (position one past the notch). Each item passes the registered
// read of the wiring and inverse table memories, then the output register. One
// item is taken every clock cycle; a stalled output holds the pipeline once
// both stages fill.
// Tables hold no defined value until loaded; configuration writes take effect
// at once and are expected only while no item is in flight.
module cipher_rotor_stage_unit #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // table_index[4:0], letter_in[9:5], zero fill [15:10]
    input  logic [15:0]                     s_tdata,
    // command[1:0]
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // letter_out[4:0], past_notch[5], position[10:6], zero fill [15:11]
    output logic [15:0]                     m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crs_pkg::LETTER_W-1:0]    cfg_data
);

    localparam int LW     = crs_pkg::LETTER_W;
    localparam int ADDR_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    logic [LW-1:0]     start_reg;
    logic [LW-1:0]     notch_reg;
    logic              accept;
    crs_pkg::cmd_t     command;
    crs_pkg::issue_t   info;
    logic              wir_wr_en;
    logic [ADDR_W-1:0] wir_wr_addr;
    logic [LW-1:0]     wir_wr_data;
    logic [ADDR_W-1:0] wir_rd_addr;
    logic [LW-1:0]     wir_rd_data;
    logic              inv_wr_en;
    logic [ADDR_W-1:0] inv_wr_addr;
    logic [LW-1:0]     inv_wr_data;
    logic [ADDR_W-1:0] inv_rd_addr;
    logic [LW-1:0]     inv_rd_data;
    logic [LW-1:0]     letter_out;
    logic              past_notch;
    logic [LW-1:0]     position;

    // Configuration registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            notch_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == crs_pkg::CFG_START_OFFSET) begin
                start_reg <= cfg_data;
            end else if (cfg_index == crs_pkg::CFG_NOTCH_LETTER) begin
                notch_reg <= cfg_data;
            end
        end
    end

    assign accept  = s_tvalid && s_tready;
    assign command = crs_pkg::cmd_t'(s_tuser);

    crs_issue #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ADDR_W        (ADDR_W)
    ) u_issue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .command      (command),
        .table_index  (s_tdata[4:0]),
        .letter_in    (s_tdata[9:5]),
        .start_offset (start_reg),
        .notch_letter (notch_reg),
        .wir_wr_en    (wir_wr_en),
        .wir_wr_addr  (wir_wr_addr),
        .wir_wr_data  (wir_wr_data),
        .wir_rd_addr  (wir_rd_addr),
        .inv_wr_en    (inv_wr_en),
        .inv_wr_addr  (inv_wr_addr),
        .inv_wr_data  (inv_wr_data),
        .inv_rd_addr  (inv_rd_addr),
        .info         (info)
    );

    // Wiring table
    crs_ram #(
        .DEPTH  (ALPHABET_SIZE),
        .ADDR_W (ADDR_W),
        .DATA_W (LW)
    ) u_wiring (
        .aclk    (aclk),
        .wr_en   (wir_wr_en),
        .wr_addr (wir_wr_addr),
        .wr_data (wir_wr_data),
        .rd_en   (accept),
        .rd_addr (wir_rd_addr),
        .rd_data (wir_rd_data)
    );

    // Inverse table
    crs_ram #(
        .DEPTH  (ALPHABET_SIZE),
        .ADDR_W (ADDR_W),
        .DATA_W (LW)
    ) u_inverse (
        .aclk    (aclk),
        .wr_en   (inv_wr_en),
        .wr_addr (inv_wr_addr),
        .wr_data (inv_wr_data),
        .rd_en   (accept),
        .rd_addr (inv_rd_addr),
        .rd_data (inv_rd_data)
    );

    crs_result #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_result (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .info        (info),
        .wir_rd_data (wir_rd_data),
        .inv_rd_data (inv_rd_data),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .letter_out  (letter_out),
        .past_notch  (past_notch),
        .position    (position)
    );

    assign m_tdata = {5'b0, position, past_notch, letter_out};

    // Reported position always lies inside the alphabet
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, position} < (LW + 1)'(ALPHABET_SIZE)))
        else $error("rotor position outside the alphabet");

    // Input only backs up when both stages are full and the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the pipeline can move");

    // An item accepted into an empty pipeline shows its result after the table read and output registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !m_tvalid && s_tready && $past(!s_tvalid || !aresetn)) |=> ##1 m_tvalid)
        else $error("result missing after accepted item");

endmodule

/* hw/rtl/crs_ram.sv */
// Single-port-write, single-port-read synchronous table memory with registered read.
`timescale 1ns / 1ps

module crs_ram #(
    parameter int DEPTH  = 26,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/crs_issue.sv */
// Issue stage: rotor position, step counter, table addressing and load writes.
`timescale 1ns / 1ps

module crs_issue #(
    parameter int ALPHABET_SIZE = 26,
    parameter int ADDR_W        = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  crs_pkg::cmd_t                command,
    input  logic [crs_pkg::LETTER_W-1:0] table_index,
    input  logic [crs_pkg::LETTER_W-1:0] letter_in,
    input  logic [crs_pkg::LETTER_W-1:0] start_offset,
    input  logic [crs_pkg::LETTER_W-1:0] notch_letter,
    output logic                         wir_wr_en,
    output logic [ADDR_W-1:0]            wir_wr_addr,
    output logic [crs_pkg::LETTER_W-1:0] wir_wr_data,
    output logic [ADDR_W-1:0]            wir_rd_addr,
    output logic                         inv_wr_en,
    output logic [ADDR_W-1:0]            inv_wr_addr,
    output logic [crs_pkg::LETTER_W-1:0] inv_wr_data,
    output logic [ADDR_W-1:0]            inv_rd_addr,
    output crs_pkg::issue_t              info
);

    localparam int LW = crs_pkg::LETTER_W;
    localparam crs_pkg::letter_lut_t RED_LUT = crs_pkg::mod_lut(ALPHABET_SIZE);
    localparam logic [LW:0]   SIZE_EXT = (LW + 1)'(ALPHABET_SIZE);
    localparam logic [LW-1:0] LAST     = LW'(ALPHABET_SIZE - 1);

    logic [LW-1:0] step_reg;
    logic [LW-1:0] step_next;
    logic [LW-1:0] c_red;
    logic [LW-1:0] start_red;
    logic [LW-1:0] notch_red;
    logic [LW-1:0] turn;
    logic [LW:0]   pos_sum;
    logic [LW-1:0] pos_cur;
    logic [LW-1:0] pos_inc;
    logic [LW-1:0] pos_after;
    logic [LW:0]   fwd_sum;
    logic [LW-1:0] fwd_addr;
    logic          is_advance;
    logic          load_ok;

    // Reduce letters and registers into the alphabet
    assign c_red     = RED_LUT[letter_in];
    assign start_red = RED_LUT[start_offset];
    assign notch_red = RED_LUT[notch_letter];

    // Current position and position after an advance
    assign pos_sum = {1'b0, start_red} + {1'b0, step_reg};
    assign pos_cur = (pos_sum >= SIZE_EXT) ? LW'(pos_sum - SIZE_EXT) : pos_sum[LW-1:0];
    assign pos_inc = (pos_cur == LAST) ? '0 : pos_cur + 1'b1;

    assign is_advance = (command == crs_pkg::CMD_ADVANCE);
    assign pos_after  = is_advance ? pos_inc : pos_cur;

    // Turnover sits one past the notch, wrapping to the first letter
    assign turn = (notch_red == LAST) ? '0 : notch_red + 1'b1;

    // Advance the step counter, wrapping at the alphabet size
    assign step_next = (step_reg == LAST) ? '0 : step_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (accept && is_advance) begin
            step_reg <= step_next;
        end
    end

    // Forward lookup address: letter shifted by the position
    assign fwd_sum  = {1'b0, c_red} + {1'b0, pos_cur};
    assign fwd_addr = (fwd_sum >= SIZE_EXT) ? LW'(fwd_sum - SIZE_EXT) : fwd_sum[LW-1:0];

    // Load writes both tables; out-of-range indexes are dropped
    assign load_ok = (command == crs_pkg::CMD_LOAD) && ({1'b0, table_index} < SIZE_EXT);

    assign wir_wr_en   = accept && load_ok;
    assign wir_wr_addr = table_index[ADDR_W-1:0];
    assign wir_wr_data = c_red;
    assign wir_rd_addr = fwd_addr[ADDR_W-1:0];

    assign inv_wr_en   = accept && load_ok;
    assign inv_wr_addr = c_red[ADDR_W-1:0];
    assign inv_wr_data = table_index;
    assign inv_rd_addr = c_red[ADDR_W-1:0];

    // Context for the result stage
    assign info.cmd        = command;
    assign info.pos_cur    = pos_cur;
    assign info.pos_after  = pos_after;
    assign info.past_notch = (pos_after == turn);

endmodule

/* hw/rtl/crs_result.sv */
// Result stage: read-data stage, result formation and output register.
`timescale 1ns / 1ps

module crs_result #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  crs_pkg::issue_t              info,
    input  logic [crs_pkg::LETTER_W-1:0] wir_rd_data,
    input  logic [crs_pkg::LETTER_W-1:0] inv_rd_data,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [crs_pkg::LETTER_W-1:0] letter_out,
    output logic                         past_notch,
    output logic [crs_pkg::LETTER_W-1:0] position
);

    localparam int LW = crs_pkg::LETTER_W;
    localparam logic [LW:0] SIZE_EXT = (LW + 1)'(ALPHABET_SIZE);

    logic            rd_valid_reg;
    crs_pkg::issue_t rd_info_reg;
    logic            out_valid_reg;
    logic [LW-1:0]   letter_reg;
    logic            notch_reg;
    logic [LW-1:0]   position_reg;
    logic            out_free;
    logic            rd_move;
    logic [LW:0]     rev_diff;
    logic [LW-1:0]   rev_letter;
    logic [LW-1:0]   letter_next;

    // Output register frees when empty or being taken
    assign out_free = !out_valid_reg || out_ready;
    assign rd_move  = rd_valid_reg && out_free;
    assign in_ready = !rd_valid_reg || out_free;

    // Hold the item whose table read is in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (in_ready) begin
            rd_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_info_reg <= info;
        end
    end

    // Reverse map: inverse entry minus position, wrapped into the alphabet
    assign rev_diff   = {1'b0, inv_rd_data} - {1'b0, rd_info_reg.pos_cur};
    assign rev_letter = rev_diff[LW] ? LW'(rev_diff + SIZE_EXT) : rev_diff[LW-1:0];

    always_comb begin
        case (rd_info_reg.cmd)
            crs_pkg::CMD_FORWARD: letter_next = wir_rd_data;
            crs_pkg::CMD_REVERSE: letter_next = rev_letter;
            default:              letter_next = '0;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_move) begin
            letter_reg   <= letter_next;
            notch_reg    <= rd_info_reg.past_notch;
            position_reg <= rd_info_reg.pos_after;
        end
    end

    assign out_valid  = out_valid_reg;
    assign letter_out = letter_reg;
    assign past_notch = notch_reg;
    assign position   = position_reg;

endmodule

/* sim/tb_cipher_rotor_stage_unit.sv */
// Self-checking testbench for the cipher rotor stage: directed corner items, then random traffic.
`timescale 1ns / 1ps

module tb_cipher_rotor_stage_unit;

    localparam int LETTER_W     = crs_pkg::LETTER_W;
    localparam int CFG_IDX_W    = crs_pkg::CFG_IDX_W;
    localparam int ALPHABET     = 26;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;
    localparam int SHOWN_ERRORS = 10;
    // First register index past the defined ones; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE  = 4'd15;

    // Fields of one result item
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                past_notch;
        logic [LETTER_W-1:0] position;
    } rotor_result_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic [15:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LETTER_W-1:0]  cfg_data  = '0;

    // Rotor state as the block should hold it
    logic [LETTER_W-1:0] wiring_mem  [ALPHABET];
    logic [LETTER_W-1:0] inverse_mem [ALPHABET];
    bit                  wiring_set  [ALPHABET];
    bit                  inverse_set [ALPHABET];
    int                  step_cnt  = 0;
    logic [LETTER_W-1:0] start_reg = '0;
    logic [LETTER_W-1:0] notch_reg = '0;

    rotor_result_t rotor_results_due[$];
    int            error_count    = 0;
    int            stall_cycles   = 0;
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;

    cipher_rotor_stage_unit #(
        .ALPHABET_SIZE(ALPHABET)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int fold_letter(input logic [LETTER_W-1:0] v);
        return int'(v) % ALPHABET;
    endfunction

    function automatic int rotor_pos();
        return (fold_letter(start_reg) + step_cnt) % ALPHABET;
    endfunction

    // True when a map item would only read table entries already loaded
    function automatic bit map_reads_loaded(input crs_pkg::cmd_t cmd,
                                            input logic [LETTER_W-1:0] letter);
        if (cmd == crs_pkg::CMD_FORWARD)
            return wiring_set[(fold_letter(letter) + rotor_pos()) % ALPHABET];
        if (cmd == crs_pkg::CMD_REVERSE)
            return inverse_set[fold_letter(letter)];
        return 1'b1;
    endfunction

    // Apply one item to the rotor state and return the result it should give
    function automatic rotor_result_t rotor_predict(input crs_pkg::cmd_t cmd,
                                                    input logic [LETTER_W-1:0] index,
                                                    input logic [LETTER_W-1:0] letter);
        rotor_result_t res;
        int            c;
        int            p;
        c          = fold_letter(letter);
        res.letter = '0;
        case (cmd)
            crs_pkg::CMD_LOAD: begin
                if (int'(index) < ALPHABET) begin
                    wiring_mem[index] = LETTER_W'(c);
                    wiring_set[index] = 1'b1;
                    inverse_mem[c]    = index;
                    inverse_set[c]    = 1'b1;
                end
            end
            crs_pkg::CMD_ADVANCE: step_cnt = (step_cnt + 1) % ALPHABET;
            crs_pkg::CMD_FORWARD: res.letter = wiring_mem[(c + rotor_pos()) % ALPHABET];
            crs_pkg::CMD_REVERSE: begin
                res.letter = LETTER_W'((int'(inverse_mem[c]) + ALPHABET - rotor_pos())
                                       % ALPHABET);
            end
        endcase
        p              = rotor_pos();
        res.position   = LETTER_W'(p);
        res.past_notch = (p == (fold_letter(notch_reg) + 1) % ALPHABET);
        return res;
    endfunction

    // Offer one item, idling first at random, and record its result once accepted
    task automatic send_item(input crs_pkg::cmd_t cmd, input logic [LETTER_W-1:0] index,
                             input logic [LETTER_W-1:0] letter);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {6'b000000, letter, index};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        rotor_results_due.push_back(rotor_predict(cmd, index, letter));
    endtask

    // Drop the stream and wait until every result has come out
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (rotor_results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [LETTER_W-1:0] value);
        drain_pipeline();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        if (index == crs_pkg::CFG_START_OFFSET)
            start_reg = value;
        else if (index == crs_pkg::CFG_NOTCH_LETTER)
            notch_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Loads at both ends of the table, out-of-range indexes and a value loaded twice
    task automatic test_directed_loads();
        send_item(crs_pkg::CMD_LOAD, 5'd0, 5'd25);
        send_item(crs_pkg::CMD_LOAD, 5'd25, 5'd0);
        send_item(crs_pkg::CMD_LOAD, 5'd3, 5'd29);
        send_item(crs_pkg::CMD_LOAD, 5'd31, 5'd7);
        send_item(crs_pkg::CMD_LOAD, 5'd26, 5'd31);
        send_item(crs_pkg::CMD_LOAD, 5'd7, 5'd25);
    endtask

    // Maps at position A, including letters that need folding
    task automatic test_directed_maps();
        send_item(crs_pkg::CMD_FORWARD, 5'd0, 5'd0);
        send_item(crs_pkg::CMD_FORWARD, 5'd31, 5'd25);
        send_item(crs_pkg::CMD_FORWARD, 5'd0, 5'd29);
        send_item(crs_pkg::CMD_FORWARD, 5'd0, 5'd7);
        send_item(crs_pkg::CMD_REVERSE, 5'd0, 5'd0);
        send_item(crs_pkg::CMD_REVERSE, 5'd31, 5'd25);
        send_item(crs_pkg::CMD_REVERSE, 5'd0, 5'd29);
        send_item(crs_pkg::CMD_REVERSE, 5'd0, 5'd3);
    endtask

    // Position wrapping past Z, notch at Z, folded registers and a spare index
    task automatic test_directed_wrap();
        cfg_write(crs_pkg::CFG_START_OFFSET, 5'd25);
        cfg_write(crs_pkg::CFG_NOTCH_LETTER, 5'd25);
        send_item(crs_pkg::CMD_FORWARD, 5'd0, 5'd0);
        send_item(crs_pkg::CMD_ADVANCE, 5'd31, 5'd31);
        send_item(crs_pkg::CMD_FORWARD, 5'd0, 5'd3);
        send_item(crs_pkg::CMD_REVERSE, 5'd0, 5'd25);
        cfg_write(crs_pkg::CFG_START_OFFSET, 5'd31);
        cfg_write(crs_pkg::CFG_NOTCH_LETTER, 5'd30);
        cfg_write(CFG_LAST_SPARE, 5'd31);
        send_item(crs_pkg::CMD_REVERSE, 5'd0, 5'd29);
        send_item(crs_pkg::CMD_ADVANCE, 5'd0, 5'd0);
        send_item(crs_pkg::CMD_FORWARD, 5'd0, 5'd22);
        send_item(crs_pkg::CMD_FORWARD, 5'd0, 5'd19);
    endtask

    // Load a shuffled wiring, then mix advances, maps and stray loads
    task automatic test_random_phase(input int n_items, input int src_pct, input int sink_pct,
                                     input logic [LETTER_W-1:0] start,
                                     input logic [LETTER_W-1:0] notch);
        int                  perm [ALPHABET];
        int                  j;
        int                  tmp;
        int                  r;
        crs_pkg::cmd_t       cmd;
        logic [LETTER_W-1:0] index;
        logic [LETTER_W-1:0] letter;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        cfg_write(crs_pkg::CFG_START_OFFSET, start);
        cfg_write(crs_pkg::CFG_NOTCH_LETTER, notch);
        if ($urandom_range(0, 1) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE)),
                      LETTER_W'($urandom_range(0, 31)));
        for (int i = 0; i < ALPHABET; i++)
            perm[i] = i;
        for (int i = ALPHABET - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < ALPHABET; i++)
            send_item(crs_pkg::CMD_LOAD, LETTER_W'(i), LETTER_W'(perm[i]));
        for (int k = ALPHABET; k < n_items; k++) begin
            r      = $urandom_range(0, 99);
            letter = LETTER_W'($urandom_range(0, 31));
            index  = LETTER_W'($urandom_range(0, 31));
            if (r < 15) begin
                cmd = crs_pkg::CMD_LOAD;
                if ($urandom_range(0, 4) != 0)
                    index = LETTER_W'($urandom_range(0, ALPHABET - 1));
            end else if (r < 40) begin
                cmd = crs_pkg::CMD_ADVANCE;
            end else if (r < 70) begin
                cmd = crs_pkg::CMD_FORWARD;
            end else begin
                cmd = crs_pkg::CMD_REVERSE;
            end
            // never read an entry that has not been loaded
            if (!map_reads_loaded(cmd, letter))
                cmd = crs_pkg::CMD_LOAD;
            send_item(cmd, index, letter);
        end
    endtask

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Compare each result item with the oldest one due
    always @(posedge aclk) begin
        rotor_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (rotor_results_due.size() == 0) begin
                error_count++;
                if (error_count <= SHOWN_ERRORS)
                    $display("%0t: result with none due, m_tdata=%h", $realtime, m_tdata);
            end else begin
                want = rotor_results_due.pop_front();
                if (m_tdata[4:0] !== want.letter || m_tdata[5] !== want.past_notch
                        || m_tdata[10:6] !== want.position) begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display("%0t: expected letter %0d notch %0b pos %0d, got %0d %0b %0d",
                                 $realtime, want.letter, want.past_notch, want.position,
                                 m_tdata[4:0], m_tdata[5], m_tdata[10:6]);
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_loads();
        test_directed_maps();
        test_directed_wrap();

        test_random_phase(170, 0, 0, 5'd0, 5'd25);
        test_random_phase(170, 50, 0, LETTER_W'($urandom_range(0, 31)),
                          LETTER_W'($urandom_range(0, 31)));
        test_random_phase(170, 0, 50, 5'd31, 5'd31);
        test_random_phase(170, 18, 18, LETTER_W'($urandom_range(0, 31)), 5'd0);

        drain_pipeline();
        error_count += rotor_results_due.size();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/crs_pkg.sv
hw/rtl/crs_ram.sv
hw/rtl/crs_issue.sv
hw/rtl/crs_result.sv
hw/rtl/cipher_rotor_stage_unit.sv
sim/tb_cipher_rotor_stage_unit.sv
